// File: sv/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants for the ray versus box slab test pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  // Field and bus geometry.
  localparam int unsigned QW       = 32;
  localparam int unsigned N_AXES   = 3;
  localparam int unsigned N_LANES  = 2 * N_AXES;
  localparam int unsigned DIV_STG  = QW;
  localparam int unsigned IN_DW    = 12 * QW;
  localparam int unsigned OUT_DW   = 72;

  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};

  // One division request: |bound - origin| over |direction|.
  typedef struct packed {
    logic [QW:0]   an;
    logic [QW-1:0] ad;
    logic          neg;
    logic          ovf;
  } div_op_t;

  // One division result before saturation.
  typedef struct packed {
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
  } div_res_t;

  // Per-axis flags for the zero direction case.
  typedef struct packed {
    logic dz;
    logic in_slab;
  } axis_flag_t;

endpackage

// File: sv/ray_box_slab_intersect.sv
// Pipeline: 1 prep stage, 32 divider stages of one quotient bit each and 2 resolve
// stages lie between an accepted input word and its result word.
// Throughput: one ray-box test per cycle; a stalled output holds the whole pipe.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Pipelined slab test of one ray against one axis-aligned box per word.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect import rbsi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [IN_DW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // hit, t_near, t_far, then zero fill
  output logic [OUT_DW-1:0] out_tdata
);

  logic       adv;
  logic       p_valid, d_valid;
  div_op_t    p_op [N_LANES];
  axis_flag_t p_flag [N_AXES];
  div_res_t   d_res [N_LANES];
  axis_flag_t d_flag [N_AXES];
  logic       hit;
  logic [QW-1:0] t_near, t_far;

  // The pipe moves whenever the output word is empty or being taken.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  rbsi_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .in_word  (in_tdata),
    .valid_r  (p_valid),
    .op_r     (p_op),
    .flag_r   (p_flag)
  );

  rbsi_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (p_valid),
    .op       (p_op),
    .flag     (p_flag),
    .valid_o  (d_valid),
    .res      (d_res),
    .flag_o   (d_flag)
  );

  rbsi_resolve u_res (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (d_valid),
    .res      (d_res),
    .flag     (d_flag),
    .valid_r  (out_tvalid),
    .hit_r    (hit),
    .t_near_r (t_near),
    .t_far_r  (t_far)
  );

  assign out_tdata = {{(OUT_DW-2*QW-1){1'b0}}, t_far, t_near, hit};

  // A miss carries zero distances.
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !hit) |-> (t_near == '0 && t_far == '0))
    else $error("miss word carries nonzero distances");

  // A hit carries an ordered interval.
  a_hit_order : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && hit) |-> ($signed(t_near) <= $signed(t_far)))
    else $error("hit interval is inverted");

  // Input is refused only while a finished word waits.
  a_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // Nothing leaves the pipe right after reset.
  a_reset : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

endmodule

// File: sv/rbsi_prep.sv
// ----------------------------------------------------------------------------
// rbsi_prep
// First stage: forms the exact slab differences, their magnitudes and signs,
// the early overflow check and the zero direction flags.
// ----------------------------------------------------------------------------
module rbsi_prep import rbsi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [IN_DW-1:0]     in_word,
  output logic                 valid_r,
  output div_op_t              op_r [N_LANES],
  output axis_flag_t           flag_r [N_AXES]
);

  div_op_t    op_nxt [N_LANES];
  axis_flag_t flag_nxt [N_AXES];

  // Per axis: two differences, magnitudes, quotient sign and overflow test.
  always_comb begin
    logic signed [QW-1:0] o, d, bmin, bmax;
    logic signed [QW:0]   diff;
    logic [QW-1:0]        ad;
    for (int a = 0; a < N_AXES; a++) begin
      o    = in_word[a*QW +: QW];
      d    = in_word[(3+a)*QW +: QW];
      bmin = in_word[(6+a)*QW +: QW];
      bmax = in_word[(9+a)*QW +: QW];
      ad   = d[QW-1] ? QW'(-d) : QW'(d);
      flag_nxt[a].dz      = (d == '0);
      flag_nxt[a].in_slab = (o >= bmin) && (o <= bmax);
      for (int s = 0; s < 2; s++) begin
        diff = (s == 0) ? ({bmin[QW-1], bmin} - {o[QW-1], o})
                        : ({bmax[QW-1], bmax} - {o[QW-1], o});
        op_nxt[2*a+s].an  = diff[QW] ? (QW+1)'(-diff) : (QW+1)'(diff);
        op_nxt[2*a+s].ad  = ad;
        op_nxt[2*a+s].neg = diff[QW] ^ d[QW-1];
        // Quotient of 2^32 or more saturates regardless of the low bits.
        op_nxt[2*a+s].ovf = {15'b0, op_nxt[2*a+s].an} >= {ad, 16'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r   <= op_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

// File: sv/rbsi_div_pipe.sv
// ----------------------------------------------------------------------------
// rbsi_div_pipe
// Six restoring dividers side by side, one quotient bit per register stage.
// The axis flags and the valid bit travel alongside.
// ----------------------------------------------------------------------------
module rbsi_div_pipe import rbsi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_valid,
  input  div_op_t    op [N_LANES],
  input  axis_flag_t flag [N_AXES],
  output logic       valid_o,
  output div_res_t   res [N_LANES],
  output axis_flag_t flag_o [N_AXES]
);

  localparam int unsigned RW = QW + 17;

  logic [RW-1:0] rem_r [N_LANES][DIV_STG];
  logic [QW-1:0] quo_r [N_LANES][DIV_STG];
  logic [QW-1:0] ad_r  [N_LANES][DIV_STG];
  logic          neg_r [N_LANES][DIV_STG];
  logic          ovf_r [N_LANES][DIV_STG];
  logic          vld_r [DIV_STG];
  axis_flag_t    flg_r [DIV_STG][N_AXES];

  genvar l, k;
  for (l = 0; l < N_LANES; l++) begin : g_lane
    for (k = 0; k < DIV_STG; k++) begin : g_stg
      logic [RW-1:0]   rem_in, rem_nxt;
      logic [QW-1:0]   quo_in, quo_nxt, ad_in;
      logic [2*QW-1:0] dsh;
      logic            ge, neg_in, ovf_in;

      // Pick this stage's operands from the previous stage or the input.
      if (k == 0) begin : g_first
        assign rem_in = {op[l].an, 16'b0};
        assign quo_in = '0;
        assign ad_in  = op[l].ad;
        assign neg_in = op[l].neg;
        assign ovf_in = op[l].ovf;
      end else begin : g_next
        assign rem_in = rem_r[l][k-1];
        assign quo_in = quo_r[l][k-1];
        assign ad_in  = ad_r[l][k-1];
        assign neg_in = neg_r[l][k-1];
        assign ovf_in = ovf_r[l][k-1];
      end

      // One trial subtraction decides quotient bit QW-1-k.
      always_comb begin
        dsh     = {{QW{1'b0}}, ad_in} << (QW - 1 - k);
        ge      = {{(2*QW-RW){1'b0}}, rem_in} >= dsh;
        rem_nxt = ge ? (rem_in - dsh[RW-1:0]) : rem_in;
        quo_nxt = quo_in;
        quo_nxt[QW-1-k] = ge;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[l][k] <= rem_nxt;
          quo_r[l][k] <= quo_nxt;
          ad_r[l][k]  <= ad_in;
          neg_r[l][k] <= neg_in;
          ovf_r[l][k] <= ovf_in;
        end
      end
    end

    assign res[l].q   = quo_r[l][DIV_STG-1];
    assign res[l].neg = neg_r[l][DIV_STG-1];
    assign res[l].ovf = ovf_r[l][DIV_STG-1];
  end

  // Valid bits and axis flags keep step with the dividers.
  for (k = 0; k < DIV_STG; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (adv) begin
          vld_r[k] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          flg_r[k] <= flag;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (adv) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          flg_r[k] <= flg_r[k-1];
        end
      end
    end
  end

  assign valid_o = vld_r[DIV_STG-1];
  assign flag_o  = flg_r[DIV_STG-1];

endmodule

// File: sv/rbsi_resolve.sv
// ----------------------------------------------------------------------------
// rbsi_resolve
// Saturates the quotients, orders each slab, then narrows the interval over
// the three axes into the output register.
// ----------------------------------------------------------------------------
module rbsi_resolve import rbsi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  div_res_t        res [N_LANES],
  input  axis_flag_t      flag [N_AXES],
  output logic            valid_r,
  output logic            hit_r,
  output logic [QW-1:0]   t_near_r,
  output logic [QW-1:0]   t_far_r
);

  logic                 v1_r;
  logic signed [QW-1:0] s0_r [N_AXES], s0_nxt [N_AXES];
  logic signed [QW-1:0] s1_r [N_AXES], s1_nxt [N_AXES];
  logic                 am_r [N_AXES], am_nxt [N_AXES];
  logic                 hit_nxt;
  logic [QW-1:0]        t_near_nxt, t_far_nxt;

  // Saturate each quotient and order the two slab distances.
  always_comb begin
    logic signed [QW-1:0] t [2];
    for (int a = 0; a < N_AXES; a++) begin
      for (int s = 0; s < 2; s++) begin
        if (res[2*a+s].ovf || res[2*a+s].q[QW-1]) begin
          t[s] = res[2*a+s].neg ? Q_MIN : Q_MAX;
        end else begin
          t[s] = res[2*a+s].neg ? -$signed(res[2*a+s].q) : $signed(res[2*a+s].q);
        end
      end
      if (flag[a].dz) begin
        s0_nxt[a] = Q_MIN;
        s1_nxt[a] = Q_MAX;
        am_nxt[a] = !flag[a].in_slab;
      end else begin
        s0_nxt[a] = (t[0] > t[1]) ? t[1] : t[0];
        s1_nxt[a] = (t[0] > t[1]) ? t[0] : t[1];
        am_nxt[a] = 1'b0;
      end
    end
  end

  // Narrow the running interval axis by axis.
  always_comb begin
    logic signed [QW-1:0] lo, hi;
    logic                 miss;
    lo   = Q_MIN;
    hi   = Q_MAX;
    miss = 1'b0;
    for (int a = 0; a < N_AXES; a++) begin
      if (am_r[a] || (s0_r[a] > hi) || (lo > s1_r[a])) begin
        miss = 1'b1;
      end
      if (s0_r[a] > lo) begin
        lo = s0_r[a];
      end
      if (s1_r[a] < hi) begin
        hi = s1_r[a];
      end
    end
    hit_nxt    = !miss;
    t_near_nxt = miss ? '0 : lo;
    t_far_nxt  = miss ? '0 : hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      valid_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= in_valid;
      valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r     <= s0_nxt;
      s1_r     <= s1_nxt;
      am_r     <= am_nxt;
      hit_r    <= hit_nxt;
      t_near_r <= t_near_nxt;
      t_far_r  <= t_far_nxt;
    end
  end

endmodule
